[rtl/bdlp_pkg.sv]
// Shared types and constants for the button debounce / click / long-press block.
package bdlp_pkg;

   localparam int NUM_BUTTONS = 4;
   localparam int BTN_W       = $clog2(NUM_BUTTONS);
   localparam int DELTA_W     = 8;
   localparam int LEVELS_W    = 4;
   localparam int DEB_W       = 8;
   localparam int HOLD_W      = 16;
   localparam int ID_W        = 2;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 16;
   localparam int DIV_STEP_W  = $clog2(DEB_W);

   localparam logic [DEB_W-1:0]     DEBOUNCE_RESET   = 8'd20;
   localparam logic [HOLD_W-1:0]    LONG_PRESS_RESET = 16'd800;
   localparam logic [HOLD_W-1:0]    HOLD_MAX         = 16'hFFFF;
   localparam logic [DEB_W-1:0]     COUNT_MAX        = 8'hFF;

   localparam logic [CSR_IDX_W-1:0] REG_DEBOUNCE     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LONG_PRESS   = 1'd1;

   localparam logic EVT_CLICK = 1'b0;
   localparam logic EVT_LONG  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SCAN,
      ST_EMIT
   } bdlp_state_type;

   // one scan step handed to the button unit
   typedef struct packed {
      logic                 valid;
      logic [BTN_W-1:0]     idx;
      logic                 level;
      logic [DELTA_W-1:0]   delta;
      logic [DEB_W-1:0]     threshold;
      logic [HOLD_W-1:0]    long_ms;
   } bdlp_step_type;

   // event found by one scan step
   typedef struct packed {
      logic                 hit;
      logic                 kind;
      logic [HOLD_W-1:0]    dur;
   } bdlp_evt_type;

endpackage

[rtl/bdlp_ifs.sv]
// Valid/ready channel interfaces for tick words and event words.
interface bdlp_req_if;
   logic                           valid;
   logic                           ready;
   logic [bdlp_pkg::DELTA_W-1:0]   tick_ms;
   logic [bdlp_pkg::LEVELS_W-1:0]  raw_levels;

   modport source (output valid, output tick_ms, output raw_levels, input ready);
   modport sink   (input valid, input tick_ms, input raw_levels, output ready);
endinterface

interface bdlp_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [bdlp_pkg::ID_W-1:0]      button_id;
   logic                           event_kind;
   logic [bdlp_pkg::HOLD_W-1:0]    press_duration;
   logic                           last_event;

   modport source (output valid, output button_id, output event_kind,
                   output press_duration, output last_event, input ready);
   modport sink   (input valid, input button_id, input event_kind,
                   input press_duration, input last_event, output ready);
endinterface

[rtl/bdlp_div.sv]
// Bit-serial restoring divider: debounce time over tick delta, one quotient bit per cycle.
module bdlp_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [bdlp_pkg::DEB_W-1:0]  dividend,
   input  logic [bdlp_pkg::DEB_W-1:0]  divisor,
   output logic                        done,
   output logic [bdlp_pkg::DEB_W-1:0]  quotient
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [bdlp_pkg::DIV_STEP_W-1:0]    step_ff, step_in;
   logic [bdlp_pkg::DEB_W-1:0]         rem_ff, rem_in;
   logic [bdlp_pkg::DEB_W-1:0]         quo_ff, quo_in;
   logic [bdlp_pkg::DEB_W-1:0]         dvs_ff, dvs_in;
   logic [bdlp_pkg::DEB_W:0]           shl;
   logic [bdlp_pkg::DEB_W:0]           diff;
   logic                               fits;
   logic                               last_step;

   always_comb begin
      shl       = {rem_ff, quo_ff[bdlp_pkg::DEB_W-1]};
      diff      = shl - {1'b0, dvs_ff};
      fits      = (shl >= {1'b0, dvs_ff});
      last_step = (step_ff == bdlp_pkg::DIV_STEP_W'(bdlp_pkg::DEB_W - 1));

      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;

      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[bdlp_pkg::DEB_W-1:0] : shl[bdlp_pkg::DEB_W-1:0];
         quo_in  = {quo_ff[bdlp_pkg::DEB_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   // partial remainder stays below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (rem_ff < dvs_ff))
      else $error("divider remainder out of range");

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider restarted while busy");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a run");

endmodule

[rtl/bdlp_btn.sv]
// Per-button debounce, hold timer and event detection, one button per scan step.
module bdlp_btn (
   input  logic                    clock,
   input  logic                    reset,
   input  bdlp_pkg::bdlp_step_type step,
   output bdlp_pkg::bdlp_evt_type  evt
);

   logic                          stable_ff [bdlp_pkg::NUM_BUTTONS];
   logic [bdlp_pkg::DEB_W-1:0]    dcnt_ff   [bdlp_pkg::NUM_BUTTONS];
   logic [bdlp_pkg::HOLD_W-1:0]   held_ff   [bdlp_pkg::NUM_BUTTONS];
   logic                          long_ff   [bdlp_pkg::NUM_BUTTONS];

   logic                          stable_in;
   logic [bdlp_pkg::DEB_W-1:0]    dcnt_in;
   logic [bdlp_pkg::HOLD_W-1:0]   held_in;
   logic                          long_in;

   logic                          stable_rd;
   logic [bdlp_pkg::DEB_W-1:0]    dcnt_rd;
   logic [bdlp_pkg::HOLD_W-1:0]   held_rd;
   logic                          long_rd;
   logic                          differs;
   logic                          accept;
   logic [bdlp_pkg::DEB_W:0]      cnt_sum;
   logic [bdlp_pkg::DEB_W-1:0]    cnt_sat;
   logic [bdlp_pkg::HOLD_W:0]     hold_sum;
   logic [bdlp_pkg::HOLD_W-1:0]   hold_sat;

   always_comb begin
      stable_rd = stable_ff[step.idx];
      dcnt_rd   = dcnt_ff[step.idx];
      held_rd   = held_ff[step.idx];
      long_rd   = long_ff[step.idx];

      differs = (step.level != stable_rd);
      cnt_sum = {1'b0, dcnt_rd} + 1'b1;
      cnt_sat = cnt_sum[bdlp_pkg::DEB_W] ? bdlp_pkg::COUNT_MAX : cnt_sum[bdlp_pkg::DEB_W-1:0];
      accept  = differs && (cnt_sat >= step.threshold);

      stable_in = stable_rd;
      dcnt_in   = '0;
      held_in   = held_rd;
      long_in   = long_rd;
      evt       = '0;

      if (differs && !accept) begin
         dcnt_in = cnt_sat;
      end
      if (accept) begin
         stable_in = step.level;
         held_in   = '0;
         if (step.level == 1'b0) begin
            long_in = 1'b0;
         end else if (!long_rd) begin
            evt.hit  = 1'b1;
            evt.kind = bdlp_pkg::EVT_CLICK;
            evt.dur  = held_rd;
         end
      end

      // hold timer runs on the post-debounce level
      hold_sum = {1'b0, held_in} + {{(bdlp_pkg::HOLD_W-bdlp_pkg::DELTA_W+1){1'b0}}, step.delta};
      hold_sat = hold_sum[bdlp_pkg::HOLD_W] ? bdlp_pkg::HOLD_MAX
                                             : hold_sum[bdlp_pkg::HOLD_W-1:0];
      if (stable_in == 1'b0) begin
         held_in = hold_sat;
         if (!long_in && (hold_sat >= step.long_ms)) begin
            long_in  = 1'b1;
            evt.hit  = 1'b1;
            evt.kind = bdlp_pkg::EVT_LONG;
            evt.dur  = hold_sat;
         end
      end

      if (!step.valid) begin
         evt = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < bdlp_pkg::NUM_BUTTONS; i++) begin
            stable_ff[i] <= 1'b1;
            dcnt_ff[i]   <= '0;
            held_ff[i]   <= '0;
            long_ff[i]   <= 1'b0;
         end
      end else if (step.valid) begin
         stable_ff[step.idx] <= stable_in;
         dcnt_ff[step.idx]   <= dcnt_in;
         held_ff[step.idx]   <= held_in;
         long_ff[step.idx]   <= long_in;
      end
   end

   // a press never reports a click
   a_press_clears_long: assert property (@(posedge clock) disable iff (reset)
      (step.valid && accept && step.level == 1'b0) |-> !evt.hit || evt.kind == bdlp_pkg::EVT_LONG)
      else $error("click reported on a press");

   a_click_needs_release: assert property (@(posedge clock) disable iff (reset)
      (evt.hit && evt.kind == bdlp_pkg::EVT_CLICK) |-> (accept && step.level == 1'b1))
      else $error("click without accepted release");

   // a fresh press clears the old flag, so it may fire again on that same step
   a_long_once: assert property (@(posedge clock) disable iff (reset)
      (evt.hit && evt.kind == bdlp_pkg::EVT_LONG)
      |-> (!long_rd || (accept && step.level == 1'b0)))
      else $error("long press fired twice");

endmodule

[rtl/button_debounce_click_long_press_top.sv]
// Top level: tick intake, serial divide, button scan and event output register.
//
//   channel   dir   payload                                             handshake
//   req_chan  in    tick_ms[7:0], raw_levels[3:0]                       valid/ready
//   rsp_chan  out   button_id[1:0], event_kind, press_duration[15:0],   valid/ready
//                   last_event
//   csr_*     in    csr_index[0], csr_wdata[15:0]                       csr_we
//
// A tick passes through intake, the serial divide (the quotient bits one at a time, then a
// done strobe), the scan (one button each) and the emit state (one event word per load)
// before the block is idle again. Reset is synchronous and restores every
// button to released with cleared counters. A stalled sink holds the event in the
// output register; the next tick is taken once the previous tick's events are all loaded.
module button_debounce_click_long_press_top (
   input  logic                              clock,
   input  logic                              reset,
   bdlp_req_if.sink                          req_chan,
   bdlp_rsp_if.source                        rsp_chan,
   input  logic                              csr_we,
   input  logic [bdlp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bdlp_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   bdlp_pkg::bdlp_state_type          state_ff, state_in;
   logic [bdlp_pkg::DEB_W-1:0]        deb_ms_ff;
   logic [bdlp_pkg::HOLD_W-1:0]       long_ms_ff;
   logic [bdlp_pkg::DELTA_W-1:0]      delta_ff;
   logic [bdlp_pkg::LEVELS_W-1:0]     levels_ff;
   logic [bdlp_pkg::BTN_W-1:0]        idx_ff, idx_in;
   logic [bdlp_pkg::NUM_BUTTONS-1:0]  pend_ff, pend_in;
   logic                              ekind_ff [bdlp_pkg::NUM_BUTTONS];
   logic [bdlp_pkg::HOLD_W-1:0]       edur_ff  [bdlp_pkg::NUM_BUTTONS];

   logic                              out_valid_ff, out_valid_in;
   logic [bdlp_pkg::ID_W-1:0]         out_id_ff;
   logic                              out_kind_ff;
   logic [bdlp_pkg::HOLD_W-1:0]       out_dur_ff;
   logic                              out_last_ff;

   logic                              req_fire;
   logic                              div_start;
   logic                              div_done;
   logic [bdlp_pkg::DEB_W-1:0]        div_quo;
   logic [bdlp_pkg::DELTA_W-1:0]      divisor;
   bdlp_pkg::bdlp_step_type           step;
   bdlp_pkg::bdlp_evt_type            evt;
   logic                              load;
   logic                              load_last;
   logic [bdlp_pkg::BTN_W-1:0]        sel;
   logic [bdlp_pkg::NUM_BUTTONS-1:0]  sel_mask;
   logic                              scan_last;

   assign req_chan.ready = (state_ff == bdlp_pkg::ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign divisor        = (req_chan.tick_ms == '0) ? bdlp_pkg::DELTA_W'(1)
                                                     : req_chan.tick_ms;
   assign div_start      = req_fire;

   bdlp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (deb_ms_ff),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      step.valid     = (state_ff == bdlp_pkg::ST_SCAN);
      step.idx       = idx_ff;
      step.level     = levels_ff[idx_ff];
      step.delta     = delta_ff;
      step.threshold = div_quo;
      step.long_ms   = long_ms_ff;
   end

   bdlp_btn u_btn (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .evt   (evt)
   );

   // lowest pending button goes out first
   always_comb begin
      sel = '0;
      for (int i = bdlp_pkg::NUM_BUTTONS - 1; i >= 0; i--) begin
         if (pend_ff[i]) begin
            sel = bdlp_pkg::BTN_W'(i);
         end
      end
      sel_mask  = bdlp_pkg::NUM_BUTTONS'(1) << sel;
      load_last = ((pend_ff & ~sel_mask) == '0);
      load      = (state_ff == bdlp_pkg::ST_EMIT) && (pend_ff != '0)
                  && (!out_valid_ff || rsp_chan.ready);
      scan_last = (idx_ff == bdlp_pkg::BTN_W'(bdlp_pkg::NUM_BUTTONS - 1));
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      out_valid_in = out_valid_ff;

      if (out_valid_ff && rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         bdlp_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = bdlp_pkg::ST_DIVIDE;
            end
         end
         bdlp_pkg::ST_DIVIDE: begin
            idx_in = '0;
            if (div_done) begin
               state_in = bdlp_pkg::ST_SCAN;
            end
         end
         bdlp_pkg::ST_SCAN: begin
            if (evt.hit) begin
               pend_in[idx_ff] = 1'b1;
            end
            idx_in = idx_ff + 1'b1;
            if (scan_last) begin
               state_in = bdlp_pkg::ST_EMIT;
            end
         end
         bdlp_pkg::ST_EMIT: begin
            if (pend_ff == '0) begin
               state_in = bdlp_pkg::ST_IDLE;
            end else if (load) begin
               pend_in[sel] = 1'b0;
               out_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = bdlp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bdlp_pkg::ST_IDLE;
         idx_ff       <= '0;
         pend_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deb_ms_ff  <= bdlp_pkg::DEBOUNCE_RESET;
         long_ms_ff <= bdlp_pkg::LONG_PRESS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            bdlp_pkg::REG_DEBOUNCE:   deb_ms_ff  <= csr_wdata[bdlp_pkg::DEB_W-1:0];
            bdlp_pkg::REG_LONG_PRESS: long_ms_ff <= csr_wdata[bdlp_pkg::HOLD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         delta_ff  <= req_chan.tick_ms;
         levels_ff <= req_chan.raw_levels;
      end
      if (step.valid && evt.hit) begin
         ekind_ff[idx_ff] <= evt.kind;
         edur_ff[idx_ff]  <= evt.dur;
      end
      if (load) begin
         out_id_ff   <= bdlp_pkg::ID_W'(sel);
         out_kind_ff <= ekind_ff[sel];
         out_dur_ff  <= edur_ff[sel];
         out_last_ff <= load_last;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.button_id      = out_id_ff;
   assign rsp_chan.event_kind     = out_kind_ff;
   assign rsp_chan.press_duration = out_dur_ff;
   assign rsp_chan.last_event     = out_last_ff;

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bdlp_pkg::ST_IDLE) |-> (pend_ff == '0))
      else $error("pending events left at idle");

   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      (load && load_last) |=> (pend_ff == '0))
      else $error("last word loaded with events still pending");

   a_pend_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff) != bdlp_pkg::ST_SCAN)
      |-> ($countones(pend_ff) <= $countones($past(pend_ff))))
      else $error("event queued outside the scan");

endmodule

[bench/button_debounce_click_long_press_top_test.sv]
// Self-checking bench for the button debouncer: ticks are driven in and every event word is predicted.
module button_debounce_click_long_press_top_test;

   typedef struct packed {
      logic [bdlp_pkg::ID_W-1:0]   button_id;
      logic                        event_kind;
      logic [bdlp_pkg::HOLD_W-1:0] press_duration;
      logic                        last_event;
   } event_word_type;

   // Tracks per-button debounce/hold state and queues the event words a tick should cause.
   class press_event_board;
      logic [bdlp_pkg::DEB_W-1:0]  debounce_ms;
      logic [bdlp_pkg::HOLD_W-1:0] long_press_ms;
      logic                        stable_lvl   [bdlp_pkg::NUM_BUTTONS];
      logic [bdlp_pkg::DEB_W-1:0]  bounce_cnt   [bdlp_pkg::NUM_BUTTONS];
      logic [bdlp_pkg::HOLD_W-1:0] hold_ms      [bdlp_pkg::NUM_BUTTONS];
      logic                        long_latched [bdlp_pkg::NUM_BUTTONS];
      event_word_type              awaited_events[$];
      int                          mismatches;

      function new();
         debounce_ms   = bdlp_pkg::DEBOUNCE_RESET;
         long_press_ms = bdlp_pkg::LONG_PRESS_RESET;
         mismatches    = 0;
         for (int b = 0; b < bdlp_pkg::NUM_BUTTONS; b++) begin
            stable_lvl[b]   = 1'b1;
            bounce_cnt[b]   = '0;
            hold_ms[b]      = '0;
            long_latched[b] = 1'b0;
         end
      endfunction

      function void set_reg(logic [bdlp_pkg::CSR_IDX_W-1:0] idx,
                            logic [bdlp_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            bdlp_pkg::REG_DEBOUNCE:   debounce_ms   = data[bdlp_pkg::DEB_W-1:0];
            bdlp_pkg::REG_LONG_PRESS: long_press_ms = data[bdlp_pkg::HOLD_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_tick(logic [bdlp_pkg::DELTA_W-1:0] delta,
                              logic [bdlp_pkg::LEVELS_W-1:0] levels);
         int unsigned    threshold;
         int unsigned    cnt;
         int unsigned    t;
         event_word_type ev;
         event_word_type tick_events[$];
         threshold = debounce_ms / ((delta == 0) ? 1 : delta);
         for (int b = 0; b < bdlp_pkg::NUM_BUTTONS; b++) begin
            if (levels[b] != stable_lvl[b]) begin
               cnt = bounce_cnt[b] + 1;
               if (cnt > bdlp_pkg::COUNT_MAX) cnt = bdlp_pkg::COUNT_MAX;
               bounce_cnt[b] = cnt[bdlp_pkg::DEB_W-1:0];
               if (cnt >= threshold) begin
                  bounce_cnt[b] = '0;
                  stable_lvl[b] = levels[b];
                  if (!levels[b]) begin
                     hold_ms[b]      = '0;
                     long_latched[b] = 1'b0;
                  end else begin
                     if (!long_latched[b]) begin
                        ev.button_id      = bdlp_pkg::ID_W'(b);
                        ev.event_kind     = bdlp_pkg::EVT_CLICK;
                        ev.press_duration = hold_ms[b];
                        ev.last_event     = 1'b0;
                        tick_events.push_back(ev);
                     end
                     hold_ms[b] = '0;
                  end
               end
            end else begin
               bounce_cnt[b] = '0;
            end
            if (!stable_lvl[b]) begin
               t = hold_ms[b] + delta;
               if (t > bdlp_pkg::HOLD_MAX) t = bdlp_pkg::HOLD_MAX;
               hold_ms[b] = t[bdlp_pkg::HOLD_W-1:0];
               if (!long_latched[b] && t >= long_press_ms) begin
                  long_latched[b]   = 1'b1;
                  ev.button_id      = bdlp_pkg::ID_W'(b);
                  ev.event_kind     = bdlp_pkg::EVT_LONG;
                  ev.press_duration = t[bdlp_pkg::HOLD_W-1:0];
                  ev.last_event     = 1'b0;
                  tick_events.push_back(ev);
               end
            end
         end
         if (tick_events.size() > 0)
            tick_events[tick_events.size()-1].last_event = 1'b1;
         foreach (tick_events[k])
            awaited_events.push_back(tick_events[k]);
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $time, msg);
         mismatches++;
      endtask

      task check_event(event_word_type got);
         event_word_type want;
         if (awaited_events.size() == 0) begin
            report($sformatf("unexpected event word id=%0d kind=%0d dur=%0d last=%0d",
                             got.button_id, got.event_kind, got.press_duration,
                             got.last_event));
         end else begin
            want = awaited_events.pop_front();
            if (got.button_id !== want.button_id)
               report($sformatf("button_id %0d, want %0d", got.button_id, want.button_id));
            if (got.event_kind !== want.event_kind)
               report($sformatf("event_kind %0d, want %0d (button %0d)",
                                got.event_kind, want.event_kind, want.button_id));
            if (got.press_duration !== want.press_duration)
               report($sformatf("press_duration %0d, want %0d (button %0d)",
                                got.press_duration, want.press_duration, want.button_id));
            if (got.last_event !== want.last_event)
               report($sformatf("last_event %0d, want %0d (button %0d)",
                                got.last_event, want.last_event, want.button_id));
         end
      endtask
   endclass

   logic                            clock;
   logic                            reset;
   logic                            csr_we;
   logic [bdlp_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [bdlp_pkg::CSR_DATA_W-1:0] csr_wdata;

   bdlp_req_if req_bus();
   bdlp_rsp_if rsp_bus();

   press_event_board board = new();

   int idle_pct  = 0;
   int stall_pct = 0;
   int hold_left = 0;

   button_debounce_click_long_press_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // event side: random stalls, plus a long hold-off when requested
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_bus.ready = 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready = ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      event_word_type w;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         w.button_id      = rsp_bus.button_id;
         w.event_kind     = rsp_bus.event_kind;
         w.press_duration = rsp_bus.press_duration;
         w.last_event     = rsp_bus.last_event;
         board.check_event(w);
      end
   end

   initial begin
      #8000000;
      $display("[button_debounce_click_long_press_top] ERROR");
      $finish;
   end

   task automatic send_tick(input logic [bdlp_pkg::DELTA_W-1:0] delta,
                            input logic [bdlp_pkg::LEVELS_W-1:0] levels);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid      = 1'b1;
      req_bus.tick_ms    = delta;
      req_bus.raw_levels = levels;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      board.note_tick(delta, levels);
      @(negedge clock);
   endtask

   // pause input until every awaited event word is out, then let a tick with no events finish
   task automatic drain_events();
      req_bus.valid = 1'b0;
      while (board.awaited_events.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_reg(input logic [bdlp_pkg::CSR_IDX_W-1:0] idx,
                            input logic [bdlp_pkg::CSR_DATA_W-1:0] data);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      board.set_reg(idx, data);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic set_timing(input logic [bdlp_pkg::DEB_W-1:0] deb,
                             input logic [bdlp_pkg::HOLD_W-1:0] long_ms);
      drain_events();
      write_reg(bdlp_pkg::REG_DEBOUNCE, bdlp_pkg::CSR_DATA_W'(deb));
      write_reg(bdlp_pkg::REG_LONG_PRESS, long_ms);
   endtask

   function automatic logic [bdlp_pkg::DELTA_W-1:0] pick_delta();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3)  return '0;
      if (r < 60) return bdlp_pkg::DELTA_W'($urandom_range(1, 40));
      if (r < 85) return bdlp_pkg::DELTA_W'($urandom_range(41, 254));
      if (r < 92) return '1;
      return bdlp_pkg::DELTA_W'($urandom);
   endfunction

   // press/release episodes held for a while, with single-tick glitches mixed in
   task automatic run_phase(input int n_ticks, input int s_idle, input int r_stall);
      int                            sent;
      int                            len;
      int                            r;
      logic [bdlp_pkg::LEVELS_W-1:0] target;
      logic [bdlp_pkg::LEVELS_W-1:0] levels;
      logic [bdlp_pkg::DELTA_W-1:0]  delta;
      idle_pct  = s_idle;
      stall_pct = r_stall;
      target    = '1;
      sent      = 0;
      while (sent < n_ticks) begin
         r = $urandom_range(0, 99);
         if (r < 80) begin
            target = bdlp_pkg::LEVELS_W'($urandom);
            len    = (r < 15) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         end else begin
            len = 1;
         end
         for (int k = 0; k < len && sent < n_ticks; k++) begin
            levels = (r < 80) ? target : bdlp_pkg::LEVELS_W'($urandom);
            delta  = pick_delta();
            send_tick(delta, levels);
            sent++;
         end
      end
   endtask

   initial begin
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = bdlp_pkg::REG_DEBOUNCE;
      csr_wdata          = '0;
      req_bus.valid      = 1'b0;
      req_bus.tick_ms    = '0;
      req_bus.raw_levels = '1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // default timing: slow debounce with zero delta, four events in one tick
      send_tick(8'd255, 4'hF);
      send_tick(8'd1,   4'h0);
      send_tick(8'd0,   4'h0);
      send_tick(8'd20,  4'h0);
      send_tick(8'd255, 4'h0);
      send_tick(8'd255, 4'h0);
      send_tick(8'd255, 4'h0);
      send_tick(8'd255, 4'hA);
      send_tick(8'd255, 4'hF);
      // zero threshold and zero long-press time
      set_timing(8'd0, 16'd0);
      send_tick(8'd1, 4'h0);
      send_tick(8'd0, 4'h0);
      send_tick(8'd1, 4'hF);
      set_timing(8'd255, 16'd1);
      send_tick(8'd128, 4'h5);
      send_tick(8'd255, 4'hF);
      set_timing(8'd0, 16'hFFFF);
      send_tick(8'd1,   4'hE);
      send_tick(8'd255, 4'hF);
      send_tick(8'd255, 4'h0);
      send_tick(8'd1,   4'h0);
      send_tick(8'd1,   4'hF);

      set_timing(8'd20, 16'd300);
      hold_left = 400;
      run_phase(30, 0, 0);
      drain_events();
      run_phase(30, 0, 0);

      set_timing(8'd255, 16'd1);
      run_phase(55, 54, 0);

      set_timing(8'd0, 16'($urandom_range(50, 600)));
      run_phase(55, 0, 54);

      set_timing(8'($urandom_range(1, 254)), 16'($urandom_range(200, 2000)));
      run_phase(60, 26, 26);

      drain_events();
      if (board.mismatches == 0)
         $display("[button_debounce_click_long_press_top] OK");
      else
         $display("[button_debounce_click_long_press_top] ERROR");
      $finish;
   end
endmodule

[files.f]
rtl/bdlp_pkg.sv
rtl/bdlp_ifs.sv
rtl/bdlp_div.sv
rtl/bdlp_btn.sv
rtl/button_debounce_click_long_press_top.sv
bench/button_debounce_click_long_press_top_test.sv
